// File: rtl/core/pma_pkg.sv
`timescale 1ns / 1ps

package pma_pkg;

   localparam int VA_W        = 48;
   localparam int CNT_W       = 32;
   localparam int VTOT_W      = 34;
   localparam int ACT_W       = 2;
   localparam int ATTR_W      = 3;
   localparam int AP_W        = 2;
   localparam int LEVEL_W     = 2;
   localparam int IDX_W       = 9;
   localparam int DESC_W      = 64;
   localparam int REQ_DATA_W  = 224;
   localparam int RSP_DATA_W  = 216;
   localparam int MAX_REGIONS = 8;
   localparam int RIDX_W      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int RCNT_W      = $clog2(MAX_REGIONS + 1);
   localparam int SHIFT_W     = 6;

   localparam logic [CNT_W-1:0]   CNT_MAX = '1;
   localparam logic [SHIFT_W-1:0] SHIFT_L1 = SHIFT_W'(30);
   localparam logic [SHIFT_W-1:0] SHIFT_L2 = SHIFT_W'(21);
   localparam logic [SHIFT_W-1:0] SHIFT_L3 = SHIFT_W'(12);
   localparam logic [AP_W-1:0]    AP_EL0_RW = AP_W'(1);

   localparam int DESC_VALID_BIT = 0;
   localparam int DESC_TABLE_BIT = 1;
   localparam int DESC_ATTR_LSB  = 2;
   localparam int DESC_AP_LSB    = 6;
   localparam int DESC_UXN_BIT   = 54;

   localparam logic [LEVEL_W-1:0] LEVEL_NONE = LEVEL_W'(0);
   localparam logic [LEVEL_W-1:0] LEVEL_1    = LEVEL_W'(1);
   localparam logic [LEVEL_W-1:0] LEVEL_2    = LEVEL_W'(2);
   localparam logic [LEVEL_W-1:0] LEVEL_3    = LEVEL_W'(3);

   typedef enum logic [ACT_W-1:0] {
      ACT_START  = 2'd0,
      ACT_REGION = 2'd1,
      ACT_AUDIT  = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic clear;
      logic add;
      logic mark_leaf;
      logic scan;
      logic update;
      logic emit;
   } pma_cmd_type;

   typedef struct packed {
      action_type action;
      logic       leaf;
      logic       scan_done;
      logic       out_busy;
   } pma_sts_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + CNT_W'(1);
   endfunction

   function automatic logic [SHIFT_W-1:0] level_shift(input logic [LEVEL_W-1:0] lvl);
      logic [SHIFT_W-1:0] s;
      unique case (lvl)
         LEVEL_1: s = SHIFT_L1;
         LEVEL_2: s = SHIFT_L2;
         LEVEL_3: s = SHIFT_L3;
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

// File: rtl/core/pma_ctrl.sv
`timescale 1ns / 1ps

module pma_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  pma_pkg::pma_sts_type sts,
   output pma_pkg::pma_cmd_type cmd
);
   import pma_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = ST_EMIT;
            unique case (sts.action)
               ACT_START:  cmd.clear = 1'b1;
               ACT_REGION: cmd.add = 1'b1;
               ACT_AUDIT: begin
                  if (sts.leaf) begin
                     cmd.mark_leaf = 1'b1;
                     state_in      = ST_SCAN;
                  end
               end
               default: ;
            endcase
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: rtl/core/pma_dp.sv
`timescale 1ns / 1ps

module pma_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  pma_pkg::pma_cmd_type                cmd,
   output pma_pkg::pma_sts_type                sts,
   input  logic [pma_pkg::ACT_W-1:0]           req_tuser,
   input  logic [pma_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                csr_we,
   input  logic [pma_pkg::ATTR_W-1:0]          csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pma_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import pma_pkg::*;

   // latched request word
   action_type           act_ff;
   logic [VA_W-1:0]      base_ff;
   logic [VA_W-1:0]      len_ff;
   logic [DESC_W-1:0]    desc_ff;
   logic [LEVEL_W-1:0]   level_ff;
   logic [VA_W-1:0]      tbase_ff;
   logic [IDX_W-1:0]     idx_ff;

   logic [VA_W-1:0]      region_base_ff [MAX_REGIONS];
   logic [VA_W-1:0]      region_len_ff  [MAX_REGIONS];
   logic [RCNT_W-1:0]    region_count_ff, region_count_in;
   logic                 region_we;

   logic [ATTR_W-1:0]    dev_attr_ff, dev_attr_in;
   logic [VA_W-1:0]      va_ff, va_in;
   logic                 leaf_ff, leaf_in;
   logic                 outside_ff, outside_in;
   logic                 device_ff, device_in;
   logic                 wx_ff, wx_in;
   logic                 status_ff, status_in;
   logic                 hit_ff, hit_in;
   logic [RCNT_W-1:0]    scan_idx_ff, scan_idx_in;

   logic [CNT_W-1:0]     leaf_cnt_ff, leaf_cnt_in;
   logic [CNT_W-1:0]     out_cnt_ff, out_cnt_in;
   logic [CNT_W-1:0]     dev_cnt_ff, dev_cnt_in;
   logic [CNT_W-1:0]     wx_cnt_ff, wx_cnt_in;
   logic [VA_W-1:0]      first_va_ff, first_va_in;
   logic                 first_vld_ff, first_vld_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 desc_leaf;
   logic                 full;
   logic [VA_W-1:0]      region_lo;
   logic [VA_W:0]        region_hi;
   logic                 region_match;
   logic [VTOT_W-1:0]    vtot;
   logic                 viol;

   // present leaf: valid, level in range, and not a table pointer above level 3
   assign desc_leaf = (level_ff != LEVEL_NONE) && desc_ff[DESC_VALID_BIT]
                    && !((level_ff != LEVEL_3) && desc_ff[DESC_TABLE_BIT]);
   assign full = (region_count_ff >= RCNT_W'(MAX_REGIONS));

   assign region_lo    = region_base_ff[scan_idx_ff[RIDX_W-1:0]];
   assign region_hi    = {1'b0, region_lo} + {1'b0, region_len_ff[scan_idx_ff[RIDX_W-1:0]]};
   assign region_match = (va_ff >= region_lo) && ({1'b0, va_ff} < region_hi);

   assign vtot = VTOT_W'(out_cnt_ff) + VTOT_W'(dev_cnt_ff) + VTOT_W'(wx_cnt_ff);
   assign viol = !hit_ff || device_ff || wx_ff;

   assign sts.action    = act_ff;
   assign sts.leaf      = desc_leaf;
   assign sts.scan_done = hit_ff || (scan_idx_ff == region_count_ff);
   assign sts.out_busy  = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      dev_attr_in     = csr_we ? csr_wdata : dev_attr_ff;
      region_count_in = region_count_ff;
      region_we       = 1'b0;
      va_in           = va_ff;
      leaf_in         = leaf_ff;
      outside_in      = outside_ff;
      device_in       = device_ff;
      wx_in           = wx_ff;
      status_in       = status_ff;
      hit_in          = hit_ff;
      scan_idx_in     = scan_idx_ff;
      leaf_cnt_in     = leaf_cnt_ff;
      out_cnt_in      = out_cnt_ff;
      dev_cnt_in      = dev_cnt_ff;
      wx_cnt_in       = wx_cnt_ff;
      first_va_in     = first_va_ff;
      first_vld_in    = first_vld_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.decode) begin
         va_in       = tbase_ff + (VA_W'(idx_ff) << level_shift(level_ff));
         leaf_in     = cmd.mark_leaf;
         outside_in  = 1'b0;
         device_in   = cmd.mark_leaf
                     && (desc_ff[DESC_ATTR_LSB +: ATTR_W] == dev_attr_ff);
         wx_in       = cmd.mark_leaf && (desc_ff[DESC_AP_LSB +: AP_W] == AP_EL0_RW)
                     && !desc_ff[DESC_UXN_BIT];
         status_in   = cmd.add && full;
         hit_in      = 1'b0;
         scan_idx_in = '0;
      end

      if (cmd.clear) begin
         region_count_in = '0;
         leaf_cnt_in     = '0;
         out_cnt_in      = '0;
         dev_cnt_in      = '0;
         wx_cnt_in       = '0;
         first_va_in     = '0;
         first_vld_in    = 1'b0;
      end

      if (cmd.add && !full) begin
         region_we       = 1'b1;
         region_count_in = region_count_ff + RCNT_W'(1);
      end

      // one region per cycle, stop on first hit
      if (cmd.scan && !hit_ff && (scan_idx_ff != region_count_ff)) begin
         hit_in      = region_match;
         scan_idx_in = scan_idx_ff + RCNT_W'(1);
      end

      if (cmd.update) begin
         outside_in  = !hit_ff;
         leaf_cnt_in = sat_inc(leaf_cnt_ff);
         if (!hit_ff) begin
            out_cnt_in = sat_inc(out_cnt_ff);
         end
         if (device_ff) begin
            dev_cnt_in = sat_inc(dev_cnt_ff);
         end
         if (wx_ff) begin
            wx_cnt_in = sat_inc(wx_cnt_ff);
         end
         if (viol && !first_vld_ff) begin
            first_va_in  = va_ff;
            first_vld_in = 1'b1;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, status_ff, vtot, first_va_ff, wx_cnt_ff, dev_cnt_ff,
                         out_cnt_ff, leaf_cnt_ff, wx_ff, device_ff, outside_ff, leaf_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_attr_ff     <= '0;
         region_count_ff <= '0;
         leaf_cnt_ff     <= '0;
         out_cnt_ff      <= '0;
         dev_cnt_ff      <= '0;
         wx_cnt_ff       <= '0;
         first_va_ff     <= '0;
         first_vld_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         hit_ff          <= 1'b0;
         scan_idx_ff     <= '0;
      end else begin
         dev_attr_ff     <= dev_attr_in;
         region_count_ff <= region_count_in;
         leaf_cnt_ff     <= leaf_cnt_in;
         out_cnt_ff      <= out_cnt_in;
         dev_cnt_ff      <= dev_cnt_in;
         wx_cnt_ff       <= wx_cnt_in;
         first_va_ff     <= first_va_in;
         first_vld_ff    <= first_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
         hit_ff          <= hit_in;
         scan_idx_ff     <= scan_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff       <= va_in;
      leaf_ff     <= leaf_in;
      outside_ff  <= outside_in;
      device_ff   <= device_in;
      wx_ff       <= wx_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.load) begin
         act_ff   <= action_type'(req_tuser);
         base_ff  <= req_tdata[0 +: VA_W];
         len_ff   <= req_tdata[VA_W +: VA_W];
         desc_ff  <= req_tdata[2*VA_W +: DESC_W];
         level_ff <= req_tdata[2*VA_W+DESC_W +: LEVEL_W];
         tbase_ff <= req_tdata[2*VA_W+DESC_W+LEVEL_W +: VA_W];
         idx_ff   <= req_tdata[3*VA_W+DESC_W+LEVEL_W +: IDX_W];
      end
      if (region_we) begin
         region_base_ff[region_count_ff[RIDX_W-1:0]] <= base_ff;
         region_len_ff[region_count_ff[RIDX_W-1:0]]  <= len_ff;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      region_count_ff <= RCNT_W'(MAX_REGIONS))
      else $error("region count beyond table depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_idx_ff <= region_count_ff)
      else $error("region scan ran past loaded regions");

   a_outside_le_total: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= leaf_cnt_ff)
      else $error("outside count exceeds leaf count");

   a_flags_need_leaf: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp_data_ff[0] || (rsp_data_ff[3:1] == 3'b000)))
      else $error("violation flag on a word that is not a leaf");

endmodule

// File: rtl/core/page_mapping_audit.sv
`timescale 1ns / 1ps
// flow: start, region and non-leaf words are latched, decoded and emitted; leaf audit words
// also scan the regions, one per cycle up to and including the first hit (at most 8), then
// update the counters before emitting; a new word is accepted only once the previous result
// is emitted, and emitting waits while the response is stalled
// reset: synchronous, clears counters, region count, first bad va and the attribute slot

module page_mapping_audit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // action
   input  logic [pma_pkg::ACT_W-1:0]       req_tuser,
   // region_base, region_length, descriptor, table_level, table_base_va, entry_index
   input  logic [pma_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // is_leaf, entry_outside, entry_device, entry_wx, total_count, outside_count,
   // device_count, wx_count, first_viol_va, violation_total, status
   output logic [pma_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [pma_pkg::ATTR_W-1:0]      csr_wdata
);
   import pma_pkg::*;

   pma_cmd_type cmd;
   pma_sts_type sts;

   pma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pma_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
